### design/tgss_pkg.sv
// Shared types and constants for the thread group slot scheduler.
package tgss_pkg;

  localparam int MAX_GROUPS  = 16;
  localparam int SPU_SLOTS   = 6;
  localparam int MAX_THREADS = 6;

  localparam int GID_W   = 4;
  localparam int THR_W   = 3;
  localparam int PRIO_W  = 8;
  localparam int CAUSE_W = 3;
  localparam int STAT_W  = 32;
  localparam int SLOT_W  = $clog2(SPU_SLOTS + 1);

  typedef enum logic [2:0] {
    OP_ADD, OP_DESTROY, OP_START, OP_SUSPEND, OP_RESUME, OP_THREAD_STOPPED, OP_JOIN, OP_BAD
  } op_e;

  typedef enum logic [2:0] {
    GS_ABSENT, GS_INIT, GS_READY, GS_RUNNING, GS_SUSPENDED
  } gstate_e;

  typedef enum logic [1:0] {RC_OK, RC_STATE, RC_PENDING, RC_MISUSE} rc_e;

  typedef enum logic [1:0] {JK_NONE, JK_GROUP_EXIT, JK_ALL_EXIT, JK_TERMINATED} kind_e;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE            = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_EXIT            = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_GROUP_EXIT      = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_GROUP_TERMINATE = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_OTHER           = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN, S_DRAIN, S_APPLY, S_DSP_CLR, S_DSP_WALK, S_DONE
  } seq_e;

  // control bundle towards the per-thread record store
  typedef struct packed {
    logic                wr_en;
    logic                clr_en;
    logic [GID_W-1:0]    grp;
    logic [THR_W-1:0]    wr_thr;
    logic [THR_W-1:0]    rd_thr;
    logic [CAUSE_W-1:0]  cause;
    logic [STAT_W-1:0]   status;
  } mem_req_t;

endpackage

### design/thread_group_slot_scheduler_top.sv
// Top level: group table, operation sequencer and dispatch walk.
// Suspend, thread_stopped and join that pass their checks scan the group's thread
// records, one record read a cycle over MAX_THREADS entries; every item then runs the
// dispatch walk, which visits each ready group in turn (at most MAX_GROUPS).
// One item at a time: no new item is taken until the last result is in the output registers.
// Reset: asynchronous, all groups absent, all thread records read as zero.
module thread_group_slot_scheduler_top
  import tgss_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               operation_i,
  input  logic [GID_W-1:0]         group_id_i,
  input  logic [THR_W-1:0]         thread_count_i,
  input  logic [PRIO_W-1:0]        priority_req_i,
  input  logic [THR_W-1:0]         thread_index_i,
  input  logic [CAUSE_W-1:0]       exit_cause_i,
  input  logic signed [STAT_W-1:0] exit_status_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               result_code_o,
  output logic [1:0]               join_kind_o,
  output logic signed [STAT_W-1:0] join_status_o,
  output logic [MAX_GROUPS-1:0]    running_groups_o,
  output logic [2:0]               group_state_out_o
);

  seq_e seq_q, seq_d;

  gstate_e           gstate_q  [MAX_GROUPS];
  logic [THR_W-1:0]  gthr_q    [MAX_GROUPS];
  logic [PRIO_W-1:0] gprio_q   [MAX_GROUPS];

  op_e                op_q;
  logic [GID_W-1:0]   gid_q;
  logic [THR_W-1:0]   cnt_q, ti_q;
  logic [PRIO_W-1:0]  prio_q;
  logic [CAUSE_W-1:0] cause_q;
  logic [STAT_W-1:0]  stat_q;

  rc_e               rc_q;
  kind_e             kind_q;
  logic [STAT_W-1:0] jstat_q;
  logic              scan_q;

  logic [THR_W-1:0]  scan_t_q, rd_t_q;
  logic              rd_live_q;
  logic              any_act_q, any_stop_q, term_q, gexit_q, all_q;
  logic [STAT_W-1:0] tstat_q, gstat_q;

  logic [SLOT_W-1:0]     left_q;
  logic [MAX_GROUPS-1:0] visited_q;

  logic                  out_valid_q;
  logic                  out_load;
  logic [MAX_GROUPS-1:0] run_q;

  mem_req_t           mreq;
  logic [CAUSE_W-1:0] rd_cause;
  logic [STAT_W-1:0]  rd_status;

  logic [MAX_GROUPS-1:0] cand;
  logic                  mf_found;
  logic [GID_W-1:0]      mf_idx;
  logic                  fits;

  gstate_e           st;
  logic [THR_W-1:0]  ths;
  rc_e               chk_rc;
  logic              chk_scan;
  logic              tbl_wr;
  gstate_e           tbl_state;
  logic [THR_W-1:0]  tbl_thr;
  logic [PRIO_W-1:0] tbl_prio;

  assign st  = gstate_q[gid_q];
  assign ths = gthr_q[gid_q];

  // operation checks and table update for the addressed group
  always_comb begin
    chk_rc      = RC_OK;
    chk_scan    = 1'b0;
    tbl_wr      = 1'b0;
    tbl_state   = st;
    tbl_thr     = ths;
    tbl_prio    = gprio_q[gid_q];
    mreq        = '0;
    mreq.grp    = gid_q;
    mreq.wr_thr = ti_q;
    mreq.rd_thr = scan_t_q;
    mreq.cause  = cause_q;
    mreq.status = stat_q;
    unique case (op_q)
      OP_ADD: begin
        if (st != GS_ABSENT) chk_rc = RC_STATE;
        else if (cnt_q == '0 || cnt_q > THR_W'(MAX_THREADS)) chk_rc = RC_MISUSE;
        else begin
          tbl_wr      = 1'b1;
          tbl_state   = GS_INIT;
          tbl_thr     = cnt_q;
          tbl_prio    = prio_q;
          mreq.clr_en = 1'b1;
        end
      end
      OP_DESTROY: begin
        if (st != GS_INIT) chk_rc = RC_STATE;
        else begin
          tbl_wr      = 1'b1;
          tbl_state   = GS_ABSENT;
          tbl_thr     = '0;
          tbl_prio    = '0;
          mreq.clr_en = 1'b1;
        end
      end
      OP_START: begin
        // later reads only use statuses whose cause was set after the start
        if (st != GS_INIT) chk_rc = RC_STATE;
        else begin
          tbl_wr      = 1'b1;
          tbl_state   = GS_READY;
          mreq.clr_en = 1'b1;
        end
      end
      OP_SUSPEND: begin
        if (st == GS_SUSPENDED) chk_rc = RC_OK;
        else if (st != GS_READY && st != GS_RUNNING) chk_rc = RC_STATE;
        else chk_scan = 1'b1;
      end
      OP_RESUME: begin
        if (st != GS_SUSPENDED) chk_rc = RC_STATE;
        else begin
          tbl_wr    = 1'b1;
          tbl_state = GS_READY;
        end
      end
      OP_THREAD_STOPPED: begin
        if (st != GS_READY && st != GS_RUNNING && st != GS_SUSPENDED) chk_rc = RC_STATE;
        else if (ti_q >= ths || cause_q == CAUSE_NONE || cause_q > CAUSE_OTHER)
          chk_rc = RC_MISUSE;
        else begin
          mreq.wr_en = 1'b1;
          chk_scan   = 1'b1;
        end
      end
      OP_JOIN: begin
        if (st == GS_ABSENT) chk_rc = RC_STATE;
        else if (st != GS_INIT) chk_rc = RC_PENDING;
        else chk_scan = 1'b1;
      end
      OP_BAD: chk_rc = RC_MISUSE;
      default: chk_rc = RC_MISUSE;
    endcase
    if (seq_q != S_CHECK) begin
      tbl_wr      = 1'b0;
      mreq.wr_en  = 1'b0;
      mreq.clr_en = 1'b0;
    end
  end

  tgss_thread_mem u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mreq),
    .rd_cause_o  (rd_cause),
    .rd_status_o (rd_status)
  );

  always_comb begin
    for (int g = 0; g < MAX_GROUPS; g++) begin
      cand[g] = (gstate_q[g] == GS_READY) && !visited_q[g];
    end
  end

  tgss_min_find u_min (
    .cand_i  (cand),
    .prio_i  (gprio_q),
    .found_o (mf_found),
    .idx_o   (mf_idx)
  );

  assign fits     = SLOT_W'(gthr_q[mf_idx]) <= left_q;
  assign out_load = (seq_q == S_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      S_IDLE:     if (in_valid_i) seq_d = S_CHECK;
      S_CHECK:    seq_d = chk_scan ? S_SCAN : S_DSP_CLR;
      S_SCAN:     if (scan_t_q == THR_W'(MAX_THREADS - 1)) seq_d = S_DRAIN;
      S_DRAIN:    seq_d = S_APPLY;
      S_APPLY:    seq_d = S_DSP_CLR;
      S_DSP_CLR:  seq_d = S_DSP_WALK;
      S_DSP_WALK: if (!mf_found) seq_d = S_DONE;
      S_DONE:     if (out_load) seq_d = S_IDLE;
      default:    seq_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  assign in_ready_o = (seq_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int g = 0; g < MAX_GROUPS; g++) begin
        gstate_q[g] <= GS_ABSENT;
        gthr_q[g]   <= '0;
        gprio_q[g]  <= '0;
      end
    end else begin
      seq_q <= seq_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (tbl_wr) begin
        gstate_q[gid_q] <= tbl_state;
        gthr_q[gid_q]   <= tbl_thr;
        gprio_q[gid_q]  <= tbl_prio;
      end
      if (seq_q == S_APPLY) begin
        if (op_q == OP_SUSPEND && !any_stop_q) gstate_q[gid_q] <= GS_SUSPENDED;
        if (op_q == OP_THREAD_STOPPED && !any_act_q) gstate_q[gid_q] <= GS_INIT;
      end
      if (seq_q == S_DSP_CLR) begin
        for (int g = 0; g < MAX_GROUPS; g++) begin
          if (gstate_q[g] == GS_RUNNING) gstate_q[g] <= GS_READY;
        end
      end
      if (seq_q == S_DSP_WALK && mf_found && fits) gstate_q[mf_idx] <= GS_RUNNING;
    end
  end

  // item capture, thread scan, dispatch bookkeeping and result registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= op_e'(operation_i);
      gid_q   <= group_id_i;
      cnt_q   <= thread_count_i;
      prio_q  <= priority_req_i;
      ti_q    <= thread_index_i;
      cause_q <= exit_cause_i;
      stat_q  <= exit_status_i;
    end
    rd_live_q <= (seq_q == S_SCAN);
    rd_t_q    <= scan_t_q;
    if (seq_q == S_CHECK) begin
      rc_q       <= chk_rc;
      scan_q     <= chk_scan;
      kind_q     <= JK_NONE;
      jstat_q    <= '0;
      scan_t_q   <= '0;
      any_act_q  <= 1'b0;
      any_stop_q <= 1'b0;
      term_q     <= 1'b0;
      gexit_q    <= 1'b0;
      all_q      <= 1'b1;
      tstat_q    <= '0;
      gstat_q    <= '0;
    end
    if (seq_q == S_SCAN) scan_t_q <= scan_t_q + THR_W'(1);
    if (rd_live_q && rd_t_q < ths) begin
      if (rd_cause == CAUSE_NONE) any_act_q <= 1'b1;
      else any_stop_q <= 1'b1;
      if (rd_cause == CAUSE_GROUP_TERMINATE) begin
        term_q  <= 1'b1;
        tstat_q <= rd_status;
      end
      if (rd_cause == CAUSE_GROUP_EXIT) begin
        gexit_q <= 1'b1;
        gstat_q <= rd_status;
      end
      if (rd_cause != CAUSE_EXIT) all_q <= 1'b0;
    end
    if (seq_q == S_APPLY && scan_q && op_q == OP_JOIN) begin
      priority if (term_q) begin
        kind_q  <= JK_TERMINATED;
        jstat_q <= tstat_q;
      end else if (gexit_q) begin
        kind_q  <= JK_GROUP_EXIT;
        jstat_q <= gstat_q;
      end else if (all_q) begin
        kind_q <= JK_ALL_EXIT;
      end
    end
    if (seq_q == S_DSP_CLR) begin
      left_q    <= SLOT_W'(SPU_SLOTS);
      visited_q <= '0;
    end
    if (seq_q == S_DSP_WALK && mf_found) begin
      visited_q[mf_idx] <= 1'b1;
      if (fits) left_q <= left_q - SLOT_W'(gthr_q[mf_idx]);
    end
    if (out_load) begin
      result_code_o     <= rc_q;
      join_kind_o       <= kind_q;
      join_status_o     <= jstat_q;
      group_state_out_o <= gstate_q[gid_q];
      for (int g = 0; g < MAX_GROUPS; g++) run_q[g] <= (gstate_q[g] == GS_RUNNING);
    end
  end

  assign running_groups_o = run_q;
  assign out_valid_o      = out_valid_q;

endmodule

### design/tgss_thread_mem.sv
// Per-thread exit cause and status store, with a valid bit per entry.
module tgss_thread_mem
  import tgss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mem_req_t           req_i,
  output logic [CAUSE_W-1:0] rd_cause_o,
  output logic [STAT_W-1:0]  rd_status_o
);

  localparam int DEPTH  = MAX_GROUPS * MAX_THREADS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [CAUSE_W+STAT_W-1:0] mem [DEPTH];
  logic [MAX_THREADS-1:0]    vld_q [MAX_GROUPS];
  logic [CAUSE_W+STAT_W-1:0] rd_q;
  logic                      rd_vld_q;
  logic [ADDR_W-1:0]         waddr, raddr;

  assign waddr = ADDR_W'(req_i.grp) * ADDR_W'(MAX_THREADS) + ADDR_W'(req_i.wr_thr);
  assign raddr = ADDR_W'(req_i.grp) * ADDR_W'(MAX_THREADS) + ADDR_W'(req_i.rd_thr);

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[waddr] <= {req_i.cause, req_i.status};
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < MAX_GROUPS; g++) vld_q[g] <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr_en) begin
        vld_q[req_i.grp] <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.grp][req_i.wr_thr] <= 1'b1;
      end
      rd_vld_q <= vld_q[req_i.grp][req_i.rd_thr];
    end
  end

  // an entry never written since its group was cleared reads as zero
  assign rd_cause_o  = rd_vld_q ? rd_q[CAUSE_W+STAT_W-1:STAT_W] : CAUSE_NONE;
  assign rd_status_o = rd_vld_q ? rd_q[STAT_W-1:0] : '0;

endmodule

### design/tgss_min_find.sv
// Compare tree picking the ready group with lowest priority, ties to lower index.
module tgss_min_find
  import tgss_pkg::*;
(
  input  logic [MAX_GROUPS-1:0] cand_i,
  input  logic [PRIO_W-1:0]     prio_i [MAX_GROUPS],
  output logic                  found_o,
  output logic [GID_W-1:0]      idx_o
);

  // heap-ordered tree, leaves at MAX_GROUPS..2*MAX_GROUPS-1 (group count is a power of two)
  logic              nv [2*MAX_GROUPS];
  logic [PRIO_W-1:0] np [2*MAX_GROUPS];
  logic [GID_W-1:0]  ni [2*MAX_GROUPS];

  always_comb begin
    nv[0] = 1'b0;
    np[0] = '0;
    ni[0] = '0;
    for (int g = 0; g < MAX_GROUPS; g++) begin
      nv[MAX_GROUPS+g] = cand_i[g];
      np[MAX_GROUPS+g] = prio_i[g];
      ni[MAX_GROUPS+g] = GID_W'(g);
    end
    for (int n = MAX_GROUPS - 1; n >= 1; n--) begin
      if (nv[2*n] && (!nv[2*n+1] || np[2*n] <= np[2*n+1])) begin
        nv[n] = 1'b1;
        np[n] = np[2*n];
        ni[n] = ni[2*n];
      end else begin
        nv[n] = nv[2*n+1];
        np[n] = np[2*n+1];
        ni[n] = ni[2*n+1];
      end
    end
  end

  assign found_o = nv[1];
  assign idx_o   = ni[1];

endmodule

### design/tgss_checker.sv
// Port-level checks for the thread group slot scheduler, bound to the top level.
module tgss_checker
  import tgss_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [1:0]               result_code_o,
  input logic [1:0]               join_kind_o,
  input logic signed [STAT_W-1:0] join_status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while the first is in work");

  a_kind_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_code_o != RC_OK |-> join_kind_o == JK_NONE && join_status_o == '0)
    else $error("join kind reported on a failed item");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (join_kind_o == JK_NONE || join_kind_o == JK_ALL_EXIT)
      |-> join_status_o == '0)
    else $error("join status set without a matching kind");

endmodule

bind thread_group_slot_scheduler_top tgss_checker u_tgss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_code_o (result_code_o),
  .join_kind_o   (join_kind_o),
  .join_status_o (join_status_o)
);

### verif/tb_thread_group_slot_scheduler_top.sv
// Self-checking testbench for the thread group slot scheduler top level.
`timescale 1ns / 1ps

module tb_thread_group_slot_scheduler_top;
  import tgss_pkg::*;

  localparam int N_RANDOM  = 900;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [2:0]        op;
    logic [GID_W-1:0]  gid;
    logic [THR_W-1:0]  cnt;
    logic [PRIO_W-1:0] prio;
    logic [THR_W-1:0]  tidx;
    logic [CAUSE_W-1:0] cause;
    logic [STAT_W-1:0] status;
  } op_item_t;

  typedef struct packed {
    logic [1:0]            rc;
    logic [1:0]            kind;
    logic [STAT_W-1:0]     jstat;
    logic [MAX_GROUPS-1:0] running;
    logic [2:0]            gstate;
  } sched_result_t;

  // directed row: item, plus a typed-in expectation where one is given
  typedef struct {
    op_item_t      item;
    logic          fixed;
    sched_result_t res;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] operation_i = '0;
  logic [GID_W-1:0] group_id_i = '0;
  logic [THR_W-1:0] thread_count_i = '0;
  logic [PRIO_W-1:0] priority_req_i = '0;
  logic [THR_W-1:0] thread_index_i = '0;
  logic [CAUSE_W-1:0] exit_cause_i = '0;
  logic signed [STAT_W-1:0] exit_status_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] result_code_o;
  logic [1:0] join_kind_o;
  logic signed [STAT_W-1:0] join_status_o;
  logic [MAX_GROUPS-1:0] running_groups_o;
  logic [2:0] group_state_out_o;

  always #10 clk_i = ~clk_i;

  thread_group_slot_scheduler_top uut (.*);

  // predictor state
  gstate_e            grp_st   [MAX_GROUPS];
  logic [THR_W-1:0]   grp_thr  [MAX_GROUPS];
  logic [PRIO_W-1:0]  grp_prio [MAX_GROUPS];
  logic [CAUSE_W-1:0] thr_cause[MAX_GROUPS][MAX_THREADS];
  logic [STAT_W-1:0]  thr_stat [MAX_GROUPS][MAX_THREADS];

  sched_result_t pending_results[$];
  int  mismatches = 0;
  bit  stim_done = 1'b0;

  function automatic bit group_has_cause(int g, bit want_zero);
    for (int t = 0; t < grp_thr[g] && t < MAX_THREADS; t++)
      if ((thr_cause[g][t] == CAUSE_NONE) == want_zero) return 1'b1;
    return 1'b0;
  endfunction

  function automatic sched_result_t schedule_step(op_item_t it);
    sched_result_t r;
    int g;
    int left;
    gstate_e st;
    bit term, gexit, all;
    logic [STAT_W-1:0] ts, gs;
    r = '0;
    g = int'(it.gid);
    st = grp_st[g];
    r.rc = RC_OK;
    case (op_e'(it.op))
      OP_ADD: begin
        if (st != GS_ABSENT) r.rc = RC_STATE;
        else if (it.cnt < 1 || it.cnt > MAX_THREADS) r.rc = RC_MISUSE;
        else begin
          grp_st[g] = GS_INIT;
          grp_thr[g] = it.cnt;
          grp_prio[g] = it.prio;
          for (int t = 0; t < MAX_THREADS; t++) begin
            thr_cause[g][t] = CAUSE_NONE;
            thr_stat[g][t] = '0;
          end
        end
      end
      OP_DESTROY: begin
        if (st != GS_INIT) r.rc = RC_STATE;
        else begin
          grp_st[g] = GS_ABSENT;
          grp_thr[g] = '0;
          grp_prio[g] = '0;
          for (int t = 0; t < MAX_THREADS; t++) begin
            thr_cause[g][t] = CAUSE_NONE;
            thr_stat[g][t] = '0;
          end
        end
      end
      OP_START: begin
        if (st != GS_INIT) r.rc = RC_STATE;
        else begin
          for (int t = 0; t < MAX_THREADS; t++) thr_cause[g][t] = CAUSE_NONE;
          grp_st[g] = GS_READY;
        end
      end
      OP_SUSPEND: begin
        if (st == GS_SUSPENDED) ;
        else if (st != GS_READY && st != GS_RUNNING) r.rc = RC_STATE;
        else if (!group_has_cause(g, 1'b0)) grp_st[g] = GS_SUSPENDED;
      end
      OP_RESUME: begin
        if (st != GS_SUSPENDED) r.rc = RC_STATE;
        else grp_st[g] = GS_READY;
      end
      OP_THREAD_STOPPED: begin
        if (st != GS_READY && st != GS_RUNNING && st != GS_SUSPENDED) r.rc = RC_STATE;
        else if (it.tidx >= grp_thr[g] || it.tidx >= MAX_THREADS ||
                 it.cause < 1 || it.cause > 4) r.rc = RC_MISUSE;
        else begin
          thr_cause[g][it.tidx] = it.cause;
          thr_stat[g][it.tidx] = it.status;
          if (!group_has_cause(g, 1'b1)) grp_st[g] = GS_INIT;
        end
      end
      OP_JOIN: begin
        if (st == GS_ABSENT) r.rc = RC_STATE;
        else if (st != GS_INIT) r.rc = RC_PENDING;
        else begin
          term = 0; gexit = 0; all = 1; ts = '0; gs = '0;
          for (int t = 0; t < grp_thr[g] && t < MAX_THREADS; t++) begin
            if (thr_cause[g][t] == CAUSE_GROUP_TERMINATE) begin term = 1; ts = thr_stat[g][t]; end
            if (thr_cause[g][t] == CAUSE_GROUP_EXIT) begin gexit = 1; gs = thr_stat[g][t]; end
            if (thr_cause[g][t] != CAUSE_EXIT) all = 0;
          end
          if (term) begin r.kind = JK_TERMINATED; r.jstat = ts; end
          else if (gexit) begin r.kind = JK_GROUP_EXIT; r.jstat = gs; end
          else if (all) r.kind = JK_ALL_EXIT;
        end
      end
      default: r.rc = RC_MISUSE;
    endcase
    // dispatch: lowest priority value first, ties to the lower index
    left = SPU_SLOTS;
    for (int i = 0; i < MAX_GROUPS; i++)
      if (grp_st[i] == GS_RUNNING) grp_st[i] = GS_READY;
    for (int p = 0; p < 256; p++)
      for (int i = 0; i < MAX_GROUPS; i++)
        if (grp_st[i] == GS_READY && grp_prio[i] == p && grp_thr[i] <= left) begin
          grp_st[i] = GS_RUNNING;
          left -= grp_thr[i];
        end
    for (int i = 0; i < MAX_GROUPS; i++) r.running[i] = (grp_st[i] == GS_RUNNING);
    r.gstate = grp_st[g];
    return r;
  endfunction

  function automatic op_item_t mk(logic [2:0] op, int g, int cnt, int prio,
                                  int ti, int cause, logic [31:0] st);
    op_item_t it;
    it.op = op; it.gid = GID_W'(g); it.cnt = THR_W'(cnt); it.prio = PRIO_W'(prio);
    it.tidx = THR_W'(ti); it.cause = CAUSE_W'(cause); it.status = st;
    return it;
  endfunction

  // mostly well-formed traffic: focus on few groups and legal fields
  function automatic op_item_t random_item();
    op_item_t it;
    it.gid = GID_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, 5));
    it.cnt = THR_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 7)
                                                 : $urandom_range(1, 6));
    it.prio = PRIO_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3));
    it.tidx = THR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                 : $urandom_range(0, it.cnt));
    it.cause = CAUSE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                    : $urandom_range(1, 4));
    it.status = $urandom;
    case ($urandom_range(0, 19))
      0, 1, 2:      it.op = OP_ADD;
      3:            it.op = OP_DESTROY;
      4, 5, 6:      it.op = OP_START;
      7:            it.op = OP_SUSPEND;
      8:            it.op = OP_RESUME;
      9, 10, 11, 12, 13, 14: it.op = OP_THREAD_STOPPED;
      15, 16, 17:   it.op = OP_JOIN;
      18:           it.op = OP_BAD;
      default:      it.op = 3'($urandom_range(0, 7));
    endcase
    return it;
  endfunction

  task automatic send_item(op_item_t it, logic fixed, sched_result_t want);
    sched_result_t pred;
    in_valid_i     <= 1'b1;
    operation_i    <= it.op;
    group_id_i     <= it.gid;
    thread_count_i <= it.cnt;
    priority_req_i <= it.prio;
    thread_index_i <= it.tidx;
    exit_cause_i   <= it.cause;
    exit_status_i  <= it.status;
    do @(posedge clk_i); while (!in_ready_o);
    pred = schedule_step(it);
    pending_results.insert(pending_results.size(), fixed ? want : pred);
  endtask

  task automatic maybe_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return;
    end
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
    burst = $urandom_range(0, 12);
  endtask

  directed_row_t rows[$];

  task automatic add_row(op_item_t it, logic fixed = 1'b0, sched_result_t r = '0);
    directed_row_t d;
    d.item = it; d.fixed = fixed; d.res = r;
    rows.insert(rows.size(), d);
  endtask

  initial begin
    int burst;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      grp_st[i] = GS_ABSENT; grp_thr[i] = '0; grp_prio[i] = '0;
      for (int t = 0; t < MAX_THREADS; t++) begin
        thr_cause[i][t] = CAUSE_NONE; thr_stat[i][t] = '0;
      end
    end
    // right after reset: join of an absent group, bad opcode
    add_row(mk(OP_JOIN, 0, 1, 0, 0, 1, 0), 1'b1, '{RC_STATE, JK_NONE, 0, 0, GS_ABSENT});
    add_row(mk(OP_BAD, 15, 7, 255, 7, 7, 32'hFFFF_FFFF), 1'b1,
            '{RC_MISUSE, JK_NONE, 0, 0, GS_ABSENT});
    add_row(mk(OP_ADD, 1, 0, 0, 0, 0, 0), 1'b1, '{RC_MISUSE, JK_NONE, 0, 0, GS_ABSENT});
    add_row(mk(OP_ADD, 1, 7, 0, 0, 0, 0), 1'b1, '{RC_MISUSE, JK_NONE, 0, 0, GS_ABSENT});
    add_row(mk(OP_ADD, 0, 6, 255, 0, 0, 0), 1'b1, '{RC_OK, JK_NONE, 0, 0, GS_INIT});
    add_row(mk(OP_JOIN, 0, 0, 0, 0, 0, 0), 1'b1, '{RC_OK, JK_NONE, 0, 0, GS_INIT});
    add_row(mk(OP_ADD, 0, 1, 0, 0, 0, 0), 1'b1, '{RC_STATE, JK_NONE, 0, 0, GS_INIT});
    add_row(mk(OP_ADD, 15, 1, 0, 0, 0, 0));
    add_row(mk(OP_ADD, 2, 3, 0, 0, 0, 0));
    add_row(mk(OP_START, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_START, 15, 0, 0, 0, 0, 0));
    add_row(mk(OP_START, 2, 0, 0, 0, 0, 0));     // fits beside group 15; the full group 0 does not
    add_row(mk(OP_SUSPEND, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_SUSPEND, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_JOIN, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_RESUME, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_THREAD_STOPPED, 15, 0, 0, 1, 1, 0));  // index beyond count
    add_row(mk(OP_THREAD_STOPPED, 15, 0, 0, 0, 5, 0));  // bad cause
    add_row(mk(OP_THREAD_STOPPED, 2, 0, 0, 0, 3, 32'h8000_0000));
    add_row(mk(OP_THREAD_STOPPED, 2, 0, 0, 1, 3, 32'h7FFF_FFFF));
    add_row(mk(OP_SUSPEND, 2, 0, 0, 0, 0, 0));          // has a stopped thread
    add_row(mk(OP_THREAD_STOPPED, 2, 0, 0, 2, 2, 32'h1234));
    add_row(mk(OP_JOIN, 2, 0, 0, 0, 0, 0));
    add_row(mk(OP_THREAD_STOPPED, 15, 0, 0, 0, 1, 0));
    add_row(mk(OP_JOIN, 15, 0, 0, 0, 0, 0));
    add_row(mk(OP_DESTROY, 15, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst = $urandom_range(0, 12);
    foreach (rows[i]) begin
      send_item(rows[i].item, rows[i].fixed, rows[i].res);
      maybe_gap(burst);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      send_item(random_item(), 1'b0, '0);
      maybe_gap(burst);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: runs of ready, runs of stall
  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 20);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      if ($urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    sched_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{result_code_o, join_kind_o, join_status_o, running_groups_o, group_state_out_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: rc %0d/%0d kind %0d/%0d stat %h/%h run %h/%h st %0d/%0d",
                     want.rc, got.rc, want.kind, got.kind, want.jstat, got.jstat,
                     want.running, got.running, want.gstate, got.gstate);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) $display("[thread_group_slot_scheduler_top] OK");
    else $display("[thread_group_slot_scheduler_top] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[thread_group_slot_scheduler_top] ERROR");
    $finish;
  end

endmodule

### thread_group_slot_scheduler_top.f
design/tgss_pkg.sv
design/tgss_thread_mem.sv
design/tgss_min_find.sv
design/thread_group_slot_scheduler_top.sv
design/tgss_checker.sv
verif/tb_thread_group_slot_scheduler_top.sv
